/* rtl/udp_checksum_engine_top_defines.svh */
// assertion macros shared by the checksum engine rtl
`ifndef UDP_CHECKSUM_ENGINE_TOP_DEFINES_SVH
`define UDP_CHECKSUM_ENGINE_TOP_DEFINES_SVH

// clocked check, off while reset is asserted
`define UDPCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define UDPCS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/udpcs_pkg.sv */
// types, constants and sum helpers of the udp checksum engine
package udpcs_pkg;

	localparam int HEADER_BYTES = 8;
	localparam logic [7:0] PROTO_RESET = 8'd17;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// header byte positions
	localparam logic [15:0] IDX_SRC_HI = 16'd0;
	localparam logic [15:0] IDX_SRC_LO = 16'd1;
	localparam logic [15:0] IDX_DST_HI = 16'd2;
	localparam logic [15:0] IDX_DST_LO = 16'd3;
	localparam logic [15:0] IDX_LEN_HI = 16'd4;
	localparam logic [15:0] IDX_LEN_LO = 16'd5;
	localparam logic [15:0] IDX_CSUM_HI = 16'd6;

	typedef struct packed {
		logic [7:0]  seg_byte;
		logic        last_byte;
		logic [15:0] addr_sum;
		logic        verify_mode;
	} byte_item_t;

	typedef struct packed {
		logic [15:0] sum;
		logic [7:0]  held;
		logic        odd;
		logic [15:0] len;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic        clamped;
		logic        short_len;
		logic        mode;
	} pkt_fin_t;

	// end-around carry fold of a sum of up to eight 16-bit words
	function automatic logic [15:0] fold19(input logic [18:0] s);
		logic [16:0] f1;
		logic [16:0] f2;
		f1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
		f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
		return f2[15:0];
	endfunction

	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		return fold19({3'd0, a} + {3'd0, b});
	endfunction

endpackage

/* rtl/udpcs_in_if.sv */
// byte channel into the checksum engine
interface udpcs_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  seg_byte;
	logic        last_byte;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic        verify_mode;

	modport source (
		output valid, seg_byte, last_byte, src_addr, dst_addr, verify_mode,
		input  ready
	);
	modport sink (
		input  valid, seg_byte, last_byte, src_addr, dst_addr, verify_mode,
		output ready
	);
endinterface

/* rtl/udpcs_out_if.sv */
// result channel out of the checksum engine
interface udpcs_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum_value;
	logic        checksum_ok;
	logic [15:0] segment_length;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic        length_clamped;
	logic        length_short;

	modport source (
		output valid, checksum_value, checksum_ok, segment_length, source_port,
		       dest_port, length_clamped, length_short,
		input  ready
	);
	modport sink (
		input  valid, checksum_value, checksum_ok, segment_length, source_port,
		       dest_port, length_clamped, length_short,
		output ready
	);
endinterface

/* rtl/udp_checksum_engine_top.sv */
// top level of the udp checksum engine with ipv4 pseudo-header
//
// in_ch carries one segment byte per item with last_byte, the two ipv4
// addresses and verify_mode (addresses and mode are taken on a packet's
// first byte). out_ch carries one result item per packet: the checksum,
// the verify flag, the length used, both ports and the length flags.
// cfg_we / cfg_wdata write protocol_number; write only while idle.
// throughput: one byte item per cycle while in_ch.ready is high, limited by
// the single 16-bit end-around add per byte pair in the accumulator.
// a packet's result passes from its last byte through the input register,
// the packet snapshot and then the final fold into the output register.
// reset clears the pipeline, the packet state and sets protocol_number to
// 17. when the receiver stalls, the result waits in the output register and
// a second one in the snapshot stage; bytes that end no packet keep flowing,
// and in_ch.ready drops only when a last byte finds both places full.
module udp_checksum_engine_top
	import udpcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	udpcs_in_if.sink    in_ch,
	udpcs_out_if.source out_ch
);

	`include "udp_checksum_engine_top_defines.svh"

	logic [7:0]  proto_q;
	logic        v_s1, v_s2, out_v_q;
	byte_item_t  item_s1, item_in;
	pkt_fin_t    fin, fin_s2;
	logic        out_free, s2_free, s1_go, s2_load, out_load, in_acc;
	logic [18:0] total;
	logic [15:0] csum;

	assign out_free = !out_v_q || out_ch.ready;
	assign s2_free  = !v_s2 || out_free;
	assign s1_go    = v_s1 && (!item_s1.last_byte || s2_free);
	assign s2_load  = s1_go && item_s1.last_byte;
	assign out_load = v_s2 && out_free;
	assign in_ch.ready = !v_s1 || s1_go;
	assign in_acc   = in_ch.valid && in_ch.ready;

	always_comb begin
		item_in.seg_byte    = in_ch.seg_byte;
		item_in.last_byte   = in_ch.last_byte;
		item_in.verify_mode = in_ch.verify_mode;
		item_in.addr_sum    = fold19({3'd0, in_ch.src_addr[31:16]} + {3'd0, in_ch.src_addr[15:0]}
			+ {3'd0, in_ch.dst_addr[31:16]} + {3'd0, in_ch.dst_addr[15:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_q <= PROTO_RESET;
		end else if (cfg_we) begin
			proto_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (s2_load) begin
				v_s2 <= 1'b1;
			end else if (out_free) begin
				v_s2 <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item_in;
		end
		if (s2_load) begin
			fin_s2 <= fin;
		end
	end

	udpcs_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (s1_go),
		.item   (item_s1),
		.fin    (fin)
	);

	// pad word, protocol and both length words close the sum
	always_comb begin
		total = {3'd0, fin_s2.sum}
			+ {3'd0, (fin_s2.odd ? {fin_s2.held, 8'd0} : 16'd0)}
			+ {11'd0, proto_q}
			+ {3'd0, fin_s2.len}
			+ {3'd0, fin_s2.len};
		csum = ~fold19(total);
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.checksum_value <= csum;
			out_ch.checksum_ok    <= fin_s2.mode && (csum == 16'd0);
			out_ch.segment_length <= fin_s2.len;
			out_ch.source_port    <= fin_s2.source_port;
			out_ch.dest_port      <= fin_s2.dest_port;
			out_ch.length_clamped <= fin_s2.clamped;
			out_ch.length_short   <= fin_s2.short_len;
		end
	end

	assign out_ch.valid = out_v_q;

	`UDPCS_ASSERT(a_ready_only_when_busy, !in_ch.ready |-> v_s1 && item_s1.last_byte && v_s2,
		"input stalled without a pending last byte and a full snapshot")
	`UDPCS_ASSERT(a_len_floor, out_v_q |-> out_ch.segment_length >= 16'(HEADER_BYTES),
		"segment length below header size")
	`UDPCS_ASSERT(a_ok_means_zero, out_v_q && out_ch.checksum_ok |-> out_ch.checksum_value == 16'd0,
		"checksum_ok with nonzero checksum")
	`UDPCS_ASSERT(a_short_len,
		out_v_q && out_ch.length_short |-> out_ch.segment_length == 16'(HEADER_BYTES),
		"short header length not floored to header size")

endmodule

/* rtl/udpcs_accum.sv */
// per-packet byte accumulator: running sum, byte count and header fields
module udpcs_accum
	import udpcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  byte_item_t item,
	output pkt_fin_t   fin
);

	logic [15:0] sum_q, count_q, hl_q, sport_q, dport_q;
	logic [7:0]  held_q;
	logic        mode_q, sat_q;

	logic [15:0] sum_n, count_n, hl_n, sport_n, dport_n;
	logic [7:0]  held_n;
	logic        mode_n, sat_n;

	logic        first, sat, incl;
	logic [7:0]  v;
	logic [15:0] base_sum, len;
	logic        clamped;

	always_comb begin
		first    = (count_q == '0);
		mode_n   = first ? item.verify_mode : mode_q;
		sat      = (count_q == COUNT_MAX);
		// addresses enter on the first byte, when the sum is still zero
		base_sum = first ? item.addr_sum : sum_q;

		priority if (count_q < IDX_LEN_HI) begin
			incl = 1'b1;
		end else if (count_q < IDX_CSUM_HI) begin
			incl = 1'b0;
		end else if (count_q < 16'(HEADER_BYTES)) begin
			incl = mode_n;
		end else begin
			incl = !mode_n || (count_q < hl_q);
		end
		v = incl ? item.seg_byte : 8'd0;

		sum_n   = base_sum;
		count_n = count_q;
		hl_n    = hl_q;
		sport_n = sport_q;
		dport_n = dport_q;
		held_n  = held_q;
		sat_n   = sat_q;

		if (sat) begin
			sat_n = 1'b1;
		end else begin
			unique case (count_q)
				IDX_SRC_HI: sport_n = {item.seg_byte, sport_q[7:0]};
				IDX_SRC_LO: sport_n = {sport_q[15:8], item.seg_byte};
				IDX_DST_HI: dport_n = {item.seg_byte, dport_q[7:0]};
				IDX_DST_LO: dport_n = {dport_q[15:8], item.seg_byte};
				IDX_LEN_HI: hl_n = {item.seg_byte, hl_q[7:0]};
				IDX_LEN_LO: hl_n = {hl_q[15:8], item.seg_byte};
				default: ;
			endcase
			if (count_q[0]) begin
				sum_n = oc_add(base_sum, {held_q, v});
			end else begin
				held_n = v;
			end
			count_n = count_q + 16'd1;
		end

		clamped = sat_n;
		len     = count_n;
		if (mode_n) begin
			len = hl_n;
			if (hl_n > count_n) begin
				len     = count_n;
				clamped = 1'b1;
			end
		end
		if (len < 16'(HEADER_BYTES)) begin
			len = 16'(HEADER_BYTES);
		end

		fin.sum         = sum_n;
		fin.held        = held_n;
		fin.odd         = count_n[0];
		fin.len         = len;
		fin.source_port = sport_n;
		fin.dest_port   = dport_n;
		fin.clamped     = clamped;
		fin.short_len   = mode_n && (hl_n < 16'(HEADER_BYTES));
		fin.mode        = mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			hl_q    <= '0;
			sport_q <= '0;
			dport_q <= '0;
			held_q  <= '0;
			mode_q  <= 1'b0;
			sat_q   <= 1'b0;
		end else if (go) begin
			if (item.last_byte) begin
				sum_q   <= '0;
				count_q <= '0;
				hl_q    <= '0;
				sport_q <= '0;
				dport_q <= '0;
				held_q  <= '0;
				mode_q  <= 1'b0;
				sat_q   <= 1'b0;
			end else begin
				sum_q   <= sum_n;
				count_q <= count_n;
				hl_q    <= hl_n;
				sport_q <= sport_n;
				dport_q <= dport_n;
				held_q  <= held_n;
				mode_q  <= mode_n;
				sat_q   <= sat_n;
			end
		end
	end

endmodule
